// ===== src/ckb_pkg.sv =====
package ckb_pkg;

  // Fixed field widths
  localparam int REG_W    = 12;   // configuration register width
  localparam int SIZE_W   = 13;   // effective sizes up to 4095
  localparam int POS_W    = 14;   // signed canvas coordinate
  localparam int ADDR_W   = 22;   // linear framebuffer address
  localparam int COLOR_W  = 32;   // color port width
  localparam int PROD_W   = 2 * REG_W;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_MAX_DIM    = 2048;
  localparam int DEF_COLOR_BITS = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH  = 3'd0,
    CFG_CANVAS_HEIGHT = 3'd1,
    CFG_SOURCE_WIDTH  = 3'd2,
    CFG_SOURCE_HEIGHT = 3'd3,
    CFG_DEST_X        = 3'd4,
    CFG_DEST_Y        = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [REG_W-1:0] canvas_width;
    logic [REG_W-1:0] canvas_height;
    logic [REG_W-1:0] source_width;
    logic [REG_W-1:0] source_height;
    logic [REG_W-1:0] dest_x;
    logic [REG_W-1:0] dest_y;
  } cfg_t;

  // Classified pixel passed from front to back
  typedef struct packed {
    logic               we;
    logic               done;
    logic [REG_W-1:0]   x;
    logic [REG_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } item_t;

endpackage

// ===== src/ckb_front.sv =====
module ckb_front #(
  parameter int MAX_DIM    = ckb_pkg::DEF_MAX_DIM,
  parameter int COLOR_BITS = ckb_pkg::DEF_COLOR_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ckb_pkg::cfg_t                  cfg,
  input  logic                           take,
  input  logic [ckb_pkg::COLOR_W-1:0]    pixel_color,
  output ckb_pkg::item_t                 item
);
  import ckb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);
  localparam logic [COLOR_W-1:0] CMASK = {COLOR_W{1'b1}} >> (COLOR_W - COLOR_BITS);

  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;
  logic [SIZE_W-1:0] eff_w, eff_h, col_inc, row_inc;
  logic              last_col, done;
  logic [POS_W-1:0]  pos_x, pos_y;
  logic              on_canvas, we;
  logic [COLOR_W-1:0] color;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [REG_W-1:0] v);
    logic [SIZE_W-1:0] e;
    e = {1'b0, v};
    if (v == '0) return SIZE_W'(1);
    if (e > MAX_SIZE) return MAX_SIZE;
    return e;
  endfunction

  // Effective sizes and end-of-row / end-of-image tests
  always_comb begin
    eff_w    = eff_size(cfg.source_width);
    eff_h    = eff_size(cfg.source_height);
    col_inc  = {{(SIZE_W-CNT_W){1'b0}}, column_count} + SIZE_W'(1);
    row_inc  = {{(SIZE_W-CNT_W){1'b0}}, row_count} + SIZE_W'(1);
    last_col = col_inc >= eff_w;
    done     = last_col && (row_inc >= eff_h);
  end

  // Clip against canvas and drop the color key
  always_comb begin
    pos_x  = {{(POS_W-REG_W){cfg.dest_x[REG_W-1]}}, cfg.dest_x}
           + {{(POS_W-CNT_W){1'b0}}, column_count};
    pos_y  = {{(POS_W-REG_W){cfg.dest_y[REG_W-1]}}, cfg.dest_y}
           + {{(POS_W-CNT_W){1'b0}}, row_count};
    on_canvas = !pos_x[POS_W-1] && !pos_y[POS_W-1]
             && (pos_x[POS_W-2:0] < {1'b0, cfg.canvas_width})
             && (pos_y[POS_W-2:0] < {1'b0, cfg.canvas_height});
    color  = pixel_color & CMASK;
    we     = on_canvas && (color != CMASK);

    item.we    = we;
    item.done  = done;
    item.x     = we ? pos_x[REG_W-1:0] : '0;
    item.y     = we ? pos_y[REG_W-1:0] : '0;
    item.color = we ? color : '0;
  end

  // Raster counters
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (done) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (last_col) begin
      column_count_next = '0;
      row_count_next    = row_count + CNT_W'(1);
    end else begin
      column_count_next = column_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ===== src/ckb_queue.sv =====
module ckb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ckb_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ckb_pkg::item_t  head
);
  import ckb_pkg::*;

  // Two-entry queue decoupling front from back
  item_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/ckb_back.sv =====
module ckb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ckb_pkg::REG_W-1:0]      canvas_width,
  input  logic                           item_valid,
  input  ckb_pkg::item_t                 item,
  output logic                           item_take,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           write_enable,
  output logic [ckb_pkg::ADDR_W-1:0]     pixel_address,
  output logic [ckb_pkg::COLOR_W-1:0]    write_color,
  output logic                           image_done
);
  import ckb_pkg::*;

  // Multiply stage
  logic               mul_valid;
  logic               mul_we, mul_done;
  logic [PROD_W-1:0]  mul_prod;
  logic [REG_W-1:0]   mul_x;
  logic [COLOR_W-1:0] mul_color;
  logic               out_load, mul_load;
  logic [PROD_W-1:0]  addr_sum;

  assign out_load  = !result_valid || result_ready;
  assign mul_load  = !mul_valid || out_load;
  assign item_take = item_valid && mul_load;
  assign addr_sum  = mul_prod + {{(PROD_W-REG_W){1'b0}}, mul_x};

  // Row times canvas width
  always_ff @(posedge clk) begin
    if (item_take) begin
      mul_we    <= item.we;
      mul_done  <= item.done;
      mul_prod  <= PROD_W'(item.y) * PROD_W'(canvas_width);
      mul_x     <= item.x;
      mul_color <= item.color;
    end
  end

  // Add column, register the result
  always_ff @(posedge clk) begin
    if (mul_valid && out_load) begin
      write_enable  <= mul_we;
      image_done    <= mul_done;
      pixel_address <= mul_we ? addr_sum[ADDR_W-1:0] : '0;
      write_color   <= mul_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (mul_load) mul_valid <= item_valid;
      if (out_load) result_valid <= mul_valid;
    end
  end

endmodule

// ===== src/color_key_blitter.sv =====
// Color key blitter: takes source pixels in raster order and returns one
// framebuffer write request per pixel, with the linear address
// (row * canvas_width + column, wrapped to 22 bits), the color, a write
// enable that is low for pixels off the canvas or equal to the all-ones
// key, and image_done on the last pixel of the source image. Throughput is
// one pixel per clock while result_ready stays high; a result passes through
// the queue, the multiply stage and the output register. A two-entry queue sits
// between the classifying front end and the address back end. Configure
// only while the block is idle; register writes leave the raster position
// unchanged.
module color_key_blitter #(
  parameter int MAX_DIM    = ckb_pkg::DEF_MAX_DIM,
  parameter int COLOR_BITS = ckb_pkg::DEF_COLOR_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ckb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ckb_pkg::REG_W-1:0]         cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [ckb_pkg::COLOR_W-1:0]       pixel_color,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              write_enable,
  output logic [ckb_pkg::ADDR_W-1:0]        pixel_address,
  output logic [ckb_pkg::COLOR_W-1:0]       write_color,
  output logic                              image_done
);
  import ckb_pkg::*;

  cfg_t  cfg;
  item_t front_item, head;
  logic  take, q_full, q_empty, q_pop;

  assign cfg_ready   = 1'b1;
  assign pixel_ready = !q_full;
  assign take        = pixel_valid && pixel_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width  <= REG_W'(800);
      cfg.canvas_height <= REG_W'(480);
      cfg.source_width  <= REG_W'(1);
      cfg.source_height <= REG_W'(1);
      cfg.dest_x        <= '0;
      cfg.dest_y        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:  cfg.canvas_width  <= cfg_data;
        CFG_CANVAS_HEIGHT: cfg.canvas_height <= cfg_data;
        CFG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data;
        CFG_SOURCE_HEIGHT: cfg.source_height <= cfg_data;
        CFG_DEST_X:        cfg.dest_x        <= cfg_data;
        CFG_DEST_Y:        cfg.dest_y        <= cfg_data;
        default:           ;
      endcase
    end
  end

  ckb_front #(
    .MAX_DIM    (MAX_DIM),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .pixel_color (pixel_color),
    .item        (front_item)
  );

  ckb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  ckb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .canvas_width  (cfg.canvas_width),
    .item_valid    (!q_empty),
    .item          (head),
    .item_take     (q_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .write_enable  (write_enable),
    .pixel_address (pixel_address),
    .write_color   (write_color),
    .image_done    (image_done)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import ckb_pkg::*;

  localparam int MAX_DIM      = DEF_MAX_DIM;
  localparam int LATENCY      = 3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_REPORTS  = 40;
  localparam logic [COLOR_W-1:0] KEY_COLOR = '1;

  // One framebuffer write request as the block should produce it
  typedef struct {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               done;
  } fb_write_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 pixel_valid;
  logic                 pixel_ready;
  logic [COLOR_W-1:0]   pixel_color;
  logic                 result_valid;
  logic                 result_ready;
  logic                 write_enable;
  logic [ADDR_W-1:0]    pixel_address;
  logic [COLOR_W-1:0]   write_color;
  logic                 image_done;

  // Shadow copy of the registers and raster position
  logic [REG_W-1:0] canvas_w = 12'd800;
  logic [REG_W-1:0] canvas_h = 12'd480;
  logic [REG_W-1:0] src_w    = 12'd1;
  logic [REG_W-1:0] src_h    = 12'd1;
  logic [REG_W-1:0] dst_x    = 12'd0;
  logic [REG_W-1:0] dst_y    = 12'd0;
  int               col_pos  = 0;
  int               row_pos  = 0;

  fb_write_t pending_writes[$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        stall_left  = 0;
  bit        quiet       = 1'b0;

  color_key_blitter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_color  (pixel_color),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .write_enable (write_enable),
    .pixel_address(pixel_address),
    .write_color  (write_color),
    .image_done   (image_done)
  );

  always #2 clk = ~clk;

  // Source size as the raster counters see it
  function automatic int eff_size(input logic [REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Expected write request for one pixel; advances the raster position
  function automatic fb_write_t predict_write(input logic [COLOR_W-1:0] color);
    fb_write_t wr;
    int        w, h, x, y, cw, ch;
    logic      on_canvas, last_col;
    longint    lin;
    w  = eff_size(src_w);
    h  = eff_size(src_h);
    cw = canvas_w;
    ch = canvas_h;
    x  = $signed(dst_x);
    y  = $signed(dst_y);
    x  = x + col_pos;
    y  = y + row_pos;
    on_canvas = (x >= 0) && (y >= 0) && (x < cw) && (y < ch);
    wr.we    = on_canvas && (color != KEY_COLOR);
    lin      = longint'(y) * cw + x;
    wr.addr  = wr.we ? lin[ADDR_W-1:0] : '0;
    wr.color = wr.we ? color : '0;
    last_col = (col_pos + 1 >= w);
    wr.done  = last_col && (row_pos + 1 >= h);
    if (wr.done) begin
      col_pos = 0;
      row_pos = 0;
    end else if (last_col) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    return wr;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Colors weighted toward the key and its neighbors
  function automatic logic [COLOR_W-1:0] random_color();
    case ($urandom_range(0, 9))
      0:       return KEY_COLOR;
      1:       return KEY_COLOR ^ (32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Register value: narrow range, or one of the 12-bit extremes or any 12-bit value
  function automatic int pick_field(input bit wide, input int lo, input int hi);
    if (!wide) return $urandom_range(lo, hi);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 12'h7FF;
      3:       return 12'h800;
      4:       return 12'hFFF;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    fb_write_t want;
    if (pending_writes.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: unexpected write request we=%0b addr=%0h color=%0h done=%0b",
                 $time, write_enable, pixel_address, write_color, image_done);
      mismatches++;
    end else begin
      want = pending_writes.pop_front();
      if (write_enable !== want.we)     report_field("write_enable", want.we, write_enable);
      if (pixel_address !== want.addr)  report_field("pixel_address", want.addr, pixel_address);
      if (write_color !== want.color)   report_field("write_color", want.color, write_color);
      if (image_done !== want.done)     report_field("image_done", want.done, image_done);
    end
  endtask

  // Result side: check each accepted request, stall ready at random
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && result_ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) stall_left--;
        result_ready <= (stall_left == 0) && !quiet ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("color_key_blitter: mismatch");
      $finish;
    end
  end

  // Register write; valid stays up until cfg_release
  task automatic write_reg(input cfg_index_t idx, input logic [REG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CANVAS_WIDTH:  canvas_w = value;
      CFG_CANVAS_HEIGHT: canvas_h = value;
      CFG_SOURCE_WIDTH:  src_w    = value;
      CFG_SOURCE_HEIGHT: src_h    = value;
      CFG_DEST_X:        dst_x    = value;
      CFG_DEST_Y:        dst_y    = value;
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int cw, input int ch, input int sw, input int sh,
                           input int dx, input int dy);
    write_reg(CFG_CANVAS_WIDTH,  REG_W'(cw));
    write_reg(CFG_CANVAS_HEIGHT, REG_W'(ch));
    write_reg(CFG_SOURCE_WIDTH,  REG_W'(sw));
    write_reg(CFG_SOURCE_HEIGHT, REG_W'(sh));
    write_reg(CFG_DEST_X,        REG_W'(dx));
    write_reg(CFG_DEST_Y,        REG_W'(dy));
    cfg_release();
  endtask

  // Send one pixel after a random gap; predict on acceptance
  task automatic send_pixel(input logic [COLOR_W-1:0] color);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_color <= color;
    do @(posedge clk); while (!pixel_ready);
    pending_writes.push_back(predict_write(color));
  endtask

  // Stop sending and wait for every outstanding request
  task automatic drain_writes();
    pixel_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  // Reset register values: 1x1 source at the canvas origin
  task automatic test_reset_values();
    quiet = 1'b1;
    send_pixel(32'h0000_0000);
    send_pixel(KEY_COLOR);
    send_pixel(32'hFFFF_FFFE);
    send_pixel(32'h8000_0001);
    drain_writes();
    quiet = 1'b0;
  endtask

  // 3x3 source around a 1x1 canvas: clipped on every side
  task automatic test_clipping();
    configure(1, 1, 3, 3, -1, -1);
    for (int i = 0; i < 9; i++)
      send_pixel(i == 4 ? 32'h8000_0001 : 32'h1111_1111 * i);
    drain_writes();
  endtask

  // Far corner of the largest canvas wraps the address; most negative offset clips
  task automatic test_address_wrap();
    configure(4095, 4095, 1, 1, 2047, 2047);
    send_pixel(32'h7FFF_FFFF);
    drain_writes();
    write_reg(CFG_DEST_X, 12'h800);
    write_reg(CFG_DEST_Y, 12'h800);
    cfg_release();
    send_pixel(32'h0000_0001);
    drain_writes();
  endtask

  // Zero width, then zero height: never a write
  task automatic test_empty_canvas();
    configure(0, 4095, 1, 1, 0, 0);
    send_pixel(32'h1234_5678);
    drain_writes();
    write_reg(CFG_CANVAS_WIDTH, 12'hFFF);
    write_reg(CFG_CANVAS_HEIGHT, 12'h000);
    cfg_release();
    send_pixel(32'h8765_4321);
    drain_writes();
  endtask

  // Zero and oversize source sizes, and shrinking the source mid-image
  task automatic test_size_limits();
    configure(16, 16, 0, 0, 0, 0);
    repeat (2) send_pixel($urandom);
    drain_writes();
    write_reg(CFG_SOURCE_WIDTH, 12'hFFF);
    write_reg(CFG_SOURCE_HEIGHT, 12'h001);
    cfg_release();
    repeat (3) send_pixel($urandom);
    drain_writes();
    // column counter already past the new width
    write_reg(CFG_SOURCE_WIDTH, 12'h002);
    cfg_release();
    send_pixel($urandom);
    drain_writes();
    write_reg(CFG_SOURCE_WIDTH, 12'h001);
    write_reg(CFG_SOURCE_HEIGHT, 12'hFFF);
    cfg_release();
    repeat (3) send_pixel($urandom);
    drain_writes();
    // row counter already past the new height
    write_reg(CFG_SOURCE_HEIGHT, 12'h002);
    cfg_release();
    send_pixel($urandom);
    drain_writes();
  endtask

  // Whole images with random placement, some partial, some extreme settings
  task automatic test_random_images();
    int sent, n, w, h, cw, ch, sw, sh, dx, dy;
    bit wide;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wide = ($urandom_range(0, 5) == 0);
      cw = pick_field(wide && $urandom_range(0, 1), 1, 40);
      ch = pick_field(wide && $urandom_range(0, 1), 1, 40);
      sw = pick_field(wide && $urandom_range(0, 1), 1, 12);
      sh = pick_field(wide && $urandom_range(0, 1), 1, 12);
      dx = wide && $urandom_range(0, 1) ? pick_field(1, 0, 0) : pick_field(0, 0, 56) - 16;
      dy = wide && $urandom_range(0, 1) ? pick_field(1, 0, 0) : pick_field(0, 0, 56) - 16;
      configure(cw, ch, sw, sh, dx, dy);
      w = eff_size(REG_W'(sw));
      h = eff_size(REG_W'(sh));
      n = $urandom_range(1, 2) * w * h + $urandom_range(0, w);
      if (n > 150) n = $urandom_range(20, 150);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (n) send_pixel(random_color());
      sent += n;
      drain_writes();
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_CANVAS_WIDTH;
    cfg_data     <= '0;
    pixel_valid  <= 1'b0;
    pixel_color  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_clipping();
    test_address_wrap();
    test_empty_canvas();
    test_size_limits();
    test_random_images();

    drain_writes();
    repeat (4 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("color_key_blitter: match");
    end else begin
      $display("color_key_blitter: mismatch");
    end
    $finish;
  end

endmodule
